@@ rtl/gvdr_pkg.sv @@
// ----------------------------------------------------------------------------
// gvdr_pkg
// Types and codes shared by the delta record parser and its result channel
// interface: parse phases, field kinds, status codes and the result record.
// ----------------------------------------------------------------------------
package gvdr_pkg;

	// Parse phase: what the next payload byte belongs to.
	typedef enum logic [3:0] {
		PH_ROW_COUNT = 4'd0,
		PH_ROW_ORD   = 4'd1,
		PH_ROW_KLEN  = 4'd2,
		PH_ROW_KEY   = 4'd3,
		PH_FILE_ID   = 4'd4,
		PH_OFFSET    = 4'd5,
		PH_TSIZE     = 4'd6,
		PH_TSTAMP    = 4'd7,
		PH_DOCLEN    = 4'd8,
		PH_REM_COUNT = 4'd9,
		PH_REM_ORD   = 4'd10,
		PH_REM_KLEN  = 4'd11,
		PH_REM_KEY   = 4'd12,
		PH_DONE      = 4'd13
	} phase_t;

	typedef logic [3:0]  kind_t;
	typedef logic [2:0]  status_t;
	typedef logic [63:0] value_t;

	// Field kinds carried on the result channel.
	localparam kind_t KIND_ROW_COUNT   = 4'd0;
	localparam kind_t KIND_ROW_ORD     = 4'd1;
	localparam kind_t KIND_ROW_KLEN    = 4'd2;
	localparam kind_t KIND_ROW_KEY     = 4'd3;
	localparam kind_t KIND_FILE_ID     = 4'd4;
	localparam kind_t KIND_OFFSET      = 4'd5;
	localparam kind_t KIND_TSIZE       = 4'd6;
	localparam kind_t KIND_TSTAMP      = 4'd7;
	localparam kind_t KIND_DOCLEN      = 4'd8;
	localparam kind_t KIND_REM_COUNT   = 4'd9;
	localparam kind_t KIND_REM_ORD     = 4'd10;
	localparam kind_t KIND_REM_KLEN    = 4'd11;
	localparam kind_t KIND_REM_KEY     = 4'd12;
	localparam kind_t KIND_SECTION_END = 4'd13;

	// Section status codes.
	localparam status_t ST_OK        = 3'd0;
	localparam status_t ST_VARINT    = 3'd1;
	localparam status_t ST_COUNT     = 3'd2;
	localparam status_t ST_KEY       = 3'd3;
	localparam status_t ST_WIDE      = 3'd4;
	localparam status_t ST_TRUNCATED = 3'd5;
	localparam status_t ST_TRAILING  = 3'd6;

	// Largest value a 32-bit field may carry.
	localparam value_t U32_MAX = 64'h0000_0000_FFFF_FFFF;

	// Varint group index at which a further byte is one too many.
	localparam logic [3:0] GRP_LIMIT = 4'd10;

	// One result record as held in the output queue.
	typedef struct packed {
		kind_t   kind;
		value_t  value;
		status_t status;
		logic    run_last;
	} result_t;

endpackage

@@ rtl/gvdr_byte_if.sv @@
// ----------------------------------------------------------------------------
// gvdr_byte_if
// Payload byte channel: one section byte per transfer, with an end flag.
// ----------------------------------------------------------------------------
interface gvdr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       payload_end;

	modport source (output valid, output payload_byte, output payload_end, input ready);
	modport sink   (input valid, input payload_byte, input payload_end, output ready);
endinterface

@@ rtl/gvdr_result_if.sv @@
// ----------------------------------------------------------------------------
// gvdr_result_if
// Result channel: one decoded field or section end per transfer.
// ----------------------------------------------------------------------------
interface gvdr_result_if
	import gvdr_pkg::*;
;
	logic    valid;
	logic    ready;
	kind_t   field_kind;
	value_t  field_value;
	status_t section_status;
	logic    run_last;

	modport source (output valid, output field_kind, output field_value,
		output section_status, output run_last, input ready);
	modport sink   (input valid, input field_kind, input field_value,
		input section_status, input run_last, output ready);
endinterface

@@ rtl/gvdr_cfg_if.sv @@
// ----------------------------------------------------------------------------
// gvdr_cfg_if
// Configuration write channel for the timestamp width register.
// ----------------------------------------------------------------------------
interface gvdr_cfg_if;
	logic valid;
	logic ready;
	logic timestamp_wide;

	modport source (output valid, output timestamp_wide, input ready);
	modport sink   (input valid, input timestamp_wide, output ready);
endinterface

@@ rtl/gap_varint_delta_record_parser.sv @@
// ----------------------------------------------------------------------------
// gap_varint_delta_record_parser
// Byte-serial decoder for one delta section of gap and varint coded records.
// ----------------------------------------------------------------------------
// The parser takes one payload byte per clock cycle and decodes it in the
// same cycle against the parse state registers; every field that the byte
// completes is written into a four-entry result queue that drains one
// transfer per cycle while the result side is ready. Most bytes give at
// most one result, so a byte can be transferred every cycle; the byte
// flagged as the section end also yields the section end record, and the
// input holds off while three or more results wait in the queue. Fields
// are offered before the section has been fully checked, so the consumer
// must drop the section when the final status is not ok. The timestamp
// width register may be written only while the parser is idle.
// ----------------------------------------------------------------------------
module gap_varint_delta_record_parser
	import gvdr_pkg::*;
#(
	parameter int KEY_LENGTH_MAX   = 65535,
	parameter int COUNT_LIMIT_LOG2 = 40
) (
	input  logic                 clk,
	input  logic                 arst_n,
	gvdr_cfg_if.sink             cfg,
	gvdr_byte_if.sink            payload,
	gvdr_result_if.source        result
);

	localparam int CW = COUNT_LIMIT_LOG2 + 1;
	localparam int KW = (KEY_LENGTH_MAX < 2) ? 1 : $clog2(KEY_LENGTH_MAX + 1);
	localparam value_t COUNT_LIMIT = 64'd1 << COUNT_LIMIT_LOG2;
	localparam value_t KEY_LIMIT   = 64'(KEY_LENGTH_MAX);
	localparam int QD = 4;

	// Configuration and parse state.
	logic          ts_wide_q;
	phase_t        phase_q, phase_d;
	value_t        acc_q, acc_d;
	logic [3:0]    grp_q, grp_d;
	logic [CW-1:0] rows_q, rows_d;
	logic [CW-1:0] rems_q, rems_d;
	value_t        prev_row_q, prev_row_d;
	value_t        prev_rem_q, prev_rem_d;
	logic [KW-1:0] key_q, key_d;
	logic [2:0]    fcnt_q, fcnt_d;
	logic          wide_q, wide_d;
	status_t       err_q, err_d;

	// Decode of the current byte.
	logic          take;
	logic [7:0]    b;
	logic          last;
	logic          f_vld;
	kind_t         f_kind;
	value_t        f_val;
	status_t       end_st;
	logic [6:0]    shamt;
	value_t        v;
	value_t        row_sum;
	value_t        rem_sum;
	logic          ts_wide_now;

	// Result queue.
	result_t       q_mem [QD];
	logic [1:0]    wr_ptr_q, rd_ptr_q;
	logic [2:0]    cnt_q;
	result_t       ent0, ent1;
	logic [1:0]    push_n;
	logic          pop;

	assign cfg.ready = 1'b1;

	// Register write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_wide_q <= 1'b1;
		end else if (cfg.valid && cfg.ready) begin
			ts_wide_q <= cfg.timestamp_wide;
		end
	end

	assign b     = payload.payload_byte;
	assign last  = payload.payload_end;
	assign take  = payload.valid && payload.ready;

	// Varint group placement and ordinal sums.
	assign shamt   = 7'(grp_q) * 7'd7;
	assign v       = acc_q | (64'(b[6:0]) << shamt[5:0]);
	assign row_sum = prev_row_q + v;
	assign rem_sum = prev_rem_q + v;
	assign ts_wide_now = (fcnt_q == 3'd0) ? ts_wide_q : wide_q;

	// Next parse state and the field completed by this byte.
	always_comb begin
		phase_d    = phase_q;
		acc_d      = acc_q;
		grp_d      = grp_q;
		rows_d     = rows_q;
		rems_d     = rems_q;
		prev_row_d = prev_row_q;
		prev_rem_d = prev_rem_q;
		key_d      = key_q;
		fcnt_d     = fcnt_q;
		wide_d     = wide_q;
		err_d      = err_q;
		f_vld      = 1'b0;
		f_kind     = KIND_ROW_COUNT;
		f_val      = '0;
		end_st     = ST_OK;

		if (err_q == ST_OK) begin
			if (phase_q == PH_DONE) begin
				err_d = ST_TRAILING;
			end else if (phase_q == PH_ROW_KEY || phase_q == PH_REM_KEY) begin
				// Key bytes pass straight through.
				f_vld  = 1'b1;
				f_kind = (phase_q == PH_ROW_KEY) ? KIND_ROW_KEY : KIND_REM_KEY;
				f_val  = 64'(b);
				key_d  = key_q - KW'(1);
				if (key_q == KW'(1)) begin
					if (phase_q == PH_ROW_KEY) begin
						phase_d = PH_FILE_ID;
					end else begin
						rems_d  = rems_q - CW'(1);
						phase_d = (rems_q == CW'(1)) ? PH_DONE : PH_REM_ORD;
					end
				end
			end else if (phase_q == PH_TSTAMP) begin
				// Fixed little-endian timestamp, width sampled on its first byte.
				wide_d = ts_wide_now;
				acc_d  = acc_q | (64'(b) << {fcnt_q, 3'b000});
				fcnt_d = fcnt_q + 3'd1;
				if ((ts_wide_now && fcnt_q == 3'd7) || (!ts_wide_now && fcnt_q == 3'd3)) begin
					f_vld   = 1'b1;
					f_kind  = KIND_TSTAMP;
					f_val   = acc_q | (64'(b) << {fcnt_q, 3'b000});
					acc_d   = '0;
					fcnt_d  = 3'd0;
					phase_d = PH_DOCLEN;
				end
			end else if (grp_q >= GRP_LIMIT) begin
				err_d = ST_VARINT;
			end else if (!b[7]) begin
				acc_d = v;
				grp_d = grp_q + 4'd1;
			end else begin
				// Final varint byte: check and emit the completed value.
				acc_d = '0;
				grp_d = 4'd0;
				case (phase_q)
					PH_ROW_COUNT: begin
						if (v > COUNT_LIMIT) begin
							err_d = ST_COUNT;
						end else begin
							f_vld   = 1'b1;
							f_kind  = KIND_ROW_COUNT;
							f_val   = v;
							rows_d  = v[CW-1:0];
							phase_d = (v != '0) ? PH_ROW_ORD : PH_REM_COUNT;
						end
					end
					PH_ROW_ORD: begin
						prev_row_d = row_sum;
						f_vld      = 1'b1;
						f_kind     = KIND_ROW_ORD;
						f_val      = row_sum;
						phase_d    = PH_ROW_KLEN;
					end
					PH_ROW_KLEN: begin
						if (v > KEY_LIMIT) begin
							err_d = ST_KEY;
						end else begin
							f_vld   = 1'b1;
							f_kind  = KIND_ROW_KLEN;
							f_val   = v;
							key_d   = v[KW-1:0];
							phase_d = (v != '0) ? PH_ROW_KEY : PH_FILE_ID;
						end
					end
					PH_FILE_ID: begin
						if (v > U32_MAX) begin
							err_d = ST_WIDE;
						end else begin
							f_vld   = 1'b1;
							f_kind  = KIND_FILE_ID;
							f_val   = v;
							phase_d = PH_OFFSET;
						end
					end
					PH_OFFSET: begin
						f_vld   = 1'b1;
						f_kind  = KIND_OFFSET;
						f_val   = v;
						phase_d = PH_TSIZE;
					end
					PH_TSIZE: begin
						if (v > U32_MAX) begin
							err_d = ST_WIDE;
						end else begin
							f_vld   = 1'b1;
							f_kind  = KIND_TSIZE;
							f_val   = v;
							phase_d = PH_TSTAMP;
						end
					end
					PH_DOCLEN: begin
						if (v > U32_MAX) begin
							err_d = ST_WIDE;
						end else begin
							f_vld   = 1'b1;
							f_kind  = KIND_DOCLEN;
							f_val   = v;
							rows_d  = rows_q - CW'(1);
							phase_d = (rows_q == CW'(1)) ? PH_REM_COUNT : PH_ROW_ORD;
						end
					end
					PH_REM_COUNT: begin
						if (v > COUNT_LIMIT) begin
							err_d = ST_COUNT;
						end else begin
							f_vld   = 1'b1;
							f_kind  = KIND_REM_COUNT;
							f_val   = v;
							rems_d  = v[CW-1:0];
							phase_d = (v != '0) ? PH_REM_ORD : PH_DONE;
						end
					end
					PH_REM_ORD: begin
						prev_rem_d = rem_sum;
						f_vld      = 1'b1;
						f_kind     = KIND_REM_ORD;
						f_val      = rem_sum;
						phase_d    = PH_REM_KLEN;
					end
					PH_REM_KLEN: begin
						if (v > KEY_LIMIT) begin
							err_d = ST_KEY;
						end else begin
							f_vld  = 1'b1;
							f_kind = KIND_REM_KLEN;
							f_val  = v;
							key_d  = v[KW-1:0];
							if (v != '0) begin
								phase_d = PH_REM_KEY;
							end else begin
								rems_d  = rems_q - CW'(1);
								phase_d = (rems_q == CW'(1)) ? PH_DONE : PH_REM_ORD;
							end
						end
					end
					default: begin
						phase_d = phase_q;
					end
				endcase
			end
		end

		// Final status, then a fresh section after the end byte.
		end_st = err_d;
		if (err_d == ST_OK && phase_d != PH_DONE) begin
			end_st = ST_TRUNCATED;
		end
		if (last) begin
			phase_d    = PH_ROW_COUNT;
			acc_d      = '0;
			grp_d      = 4'd0;
			rows_d     = '0;
			rems_d     = '0;
			prev_row_d = '0;
			prev_rem_d = '0;
			key_d      = '0;
			fcnt_d     = 3'd0;
			wide_d     = 1'b0;
			err_d      = ST_OK;
		end
	end

	// Parse state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_ROW_COUNT;
			acc_q      <= '0;
			grp_q      <= 4'd0;
			rows_q     <= '0;
			rems_q     <= '0;
			prev_row_q <= '0;
			prev_rem_q <= '0;
			key_q      <= '0;
			fcnt_q     <= 3'd0;
			wide_q     <= 1'b0;
			err_q      <= ST_OK;
		end else if (take) begin
			phase_q    <= phase_d;
			acc_q      <= acc_d;
			grp_q      <= grp_d;
			rows_q     <= rows_d;
			rems_q     <= rems_d;
			prev_row_q <= prev_row_d;
			prev_rem_q <= prev_rem_d;
			key_q      <= key_d;
			fcnt_q     <= fcnt_d;
			wide_q     <= wide_d;
			err_q      <= err_d;
		end
	end

	// Records to queue: the decoded field first, then the section end.
	always_comb begin
		ent1.kind     = KIND_SECTION_END;
		ent1.value    = '0;
		ent1.status   = end_st;
		ent1.run_last = 1'b1;
		if (f_vld) begin
			ent0.kind     = f_kind;
			ent0.value    = f_val;
			ent0.status   = ST_OK;
			ent0.run_last = !last;
		end else begin
			ent0 = ent1;
		end
		push_n = take ? (2'(f_vld) + 2'(last)) : 2'd0;
	end

	assign payload.ready = (cnt_q <= 3'd2);
	assign pop           = result.valid && result.ready;

	// Result queue storage.
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			q_mem[wr_ptr_q] <= ent0;
		end
		if (push_n == 2'd2) begin
			q_mem[wr_ptr_q + 2'd1] <= ent1;
		end
	end

	// Result queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			cnt_q    <= 3'd0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_n;
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			cnt_q <= cnt_q + 3'(push_n) - 3'(pop);
		end
	end

	assign result.valid          = (cnt_q != 3'd0);
	assign result.field_kind     = q_mem[rd_ptr_q].kind;
	assign result.field_value    = q_mem[rd_ptr_q].value;
	assign result.section_status = q_mem[rd_ptr_q].status;
	assign result.run_last       = q_mem[rd_ptr_q].run_last;

endmodule

@@ tb/tb_gap_varint_delta_record_parser.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gap_varint_delta_record_parser
// Self-checking bench for the delta record parser. Whole sections are built
// byte by byte, both well formed and damaged, and streamed into the parser
// under varying sender and receiver idling. A decoder model inside the bench
// predicts every field and section end, and each result transfer is checked
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_gap_varint_delta_record_parser;
	import gvdr_pkg::*;

	localparam int     CLK_PERIOD     = 8;
	localparam int     RESET_CYCLES   = 9;
	localparam int     KEY_MAX        = 65535;
	localparam int     COUNT_LOG2     = 40;
	localparam value_t KEY_LIMIT      = value_t'(KEY_MAX);
	localparam value_t COUNT_LIMIT    = value_t'(1) << COUNT_LOG2;
	localparam int     SETTLE_CYCLES  = 8;
	localparam int     WATCHDOG_LIMIT = 2000;
	localparam int     MAX_REPORTS    = 10;
	localparam int     RANDOM_BYTES   = 650;

	// Idling profiles for the two sides of the parser.
	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	// Faults that the section builder may plant at a random site.
	typedef enum int {FAULT_NONE, FAULT_WIDE, FAULT_LONG, FAULT_COUNT, FAULT_KEY} fault_t;

	logic clk = 1'b0;
	logic arst_n;
	logic res_ready = 1'b0;

	gvdr_cfg_if    cfg_ch ();
	gvdr_byte_if   byte_ch ();
	gvdr_result_if res_ch ();

	assign res_ch.ready = res_ready;

	gap_varint_delta_record_parser #(
		.KEY_LENGTH_MAX  (KEY_MAX),
		.COUNT_LIMIT_LOG2(COUNT_LOG2)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.payload(byte_ch),
		.result (res_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Predicted results waiting for their transfer, oldest first.
	result_t pending_fields[$];
	// Bytes of the section being built.
	logic [7:0] sec_q[$];

	int     send_idle_pct  = 0;
	int     recv_stall_pct = 0;
	int     failures       = 0;
	int     bytes_sent     = 0;
	int     pushed_now;
	fault_t fault_left     = FAULT_NONE;

	// Decoder state of the bench's own model.
	logic     ts_wide_cfg;
	phase_t   cur_phase;
	value_t   grp_acc;
	logic [6:0]  grp_shift;
	logic [40:0] rows_to_go;
	logic [40:0] removals_to_go;
	value_t   last_row_ord;
	value_t   last_rem_ord;
	logic [16:0] key_to_go;
	logic [3:0]  stamp_count;
	logic     stamp_wide;
	status_t  sticky_status;

	// ------------------------------------------------------------------------
	// Decoder model
	// ------------------------------------------------------------------------

	// Return every piece of parse state to its value at the start of a section.
	task automatic clear_section();
		cur_phase      = PH_ROW_COUNT;
		grp_acc        = '0;
		grp_shift      = '0;
		rows_to_go     = '0;
		removals_to_go = '0;
		last_row_ord   = '0;
		last_rem_ord   = '0;
		key_to_go      = '0;
		stamp_count    = '0;
		stamp_wide     = 1'b0;
		sticky_status  = ST_OK;
	endtask

	task automatic push_field(input kind_t k, input value_t v, input status_t s);
		result_t r;
		r.kind     = k;
		r.value    = v;
		r.status   = s;
		r.run_last = 1'b0;
		pending_fields = {pending_fields, r};
		pushed_now++;
	endtask

	task automatic close_removal();
		removals_to_go--;
		if (removals_to_go != 0) cur_phase = PH_REM_ORD;
		else cur_phase = PH_DONE;
	endtask

	// A varint has completed: check it and move on in the section layout.
	task automatic finish_varint(input value_t v);
		case (cur_phase)
			PH_ROW_COUNT: begin
				if (v > COUNT_LIMIT) begin
					sticky_status = ST_COUNT;
				end else begin
					push_field(KIND_ROW_COUNT, v, ST_OK);
					rows_to_go = v[40:0];
					if (v != 0) cur_phase = PH_ROW_ORD;
					else cur_phase = PH_REM_COUNT;
				end
			end
			PH_ROW_ORD: begin
				last_row_ord += v;
				push_field(KIND_ROW_ORD, last_row_ord, ST_OK);
				cur_phase = PH_ROW_KLEN;
			end
			PH_ROW_KLEN: begin
				if (v > KEY_LIMIT) begin
					sticky_status = ST_KEY;
				end else begin
					push_field(KIND_ROW_KLEN, v, ST_OK);
					key_to_go = v[16:0];
					if (v != 0) cur_phase = PH_ROW_KEY;
					else cur_phase = PH_FILE_ID;
				end
			end
			PH_FILE_ID: begin
				if (v > U32_MAX) begin
					sticky_status = ST_WIDE;
				end else begin
					push_field(KIND_FILE_ID, v, ST_OK);
					cur_phase = PH_OFFSET;
				end
			end
			PH_OFFSET: begin
				push_field(KIND_OFFSET, v, ST_OK);
				cur_phase = PH_TSIZE;
			end
			PH_TSIZE: begin
				if (v > U32_MAX) begin
					sticky_status = ST_WIDE;
				end else begin
					push_field(KIND_TSIZE, v, ST_OK);
					cur_phase = PH_TSTAMP;
				end
			end
			PH_DOCLEN: begin
				if (v > U32_MAX) begin
					sticky_status = ST_WIDE;
				end else begin
					push_field(KIND_DOCLEN, v, ST_OK);
					rows_to_go--;
					if (rows_to_go != 0) cur_phase = PH_ROW_ORD;
					else cur_phase = PH_REM_COUNT;
				end
			end
			PH_REM_COUNT: begin
				if (v > COUNT_LIMIT) begin
					sticky_status = ST_COUNT;
				end else begin
					push_field(KIND_REM_COUNT, v, ST_OK);
					removals_to_go = v[40:0];
					if (v != 0) cur_phase = PH_REM_ORD;
					else cur_phase = PH_DONE;
				end
			end
			PH_REM_ORD: begin
				last_rem_ord += v;
				push_field(KIND_REM_ORD, last_rem_ord, ST_OK);
				cur_phase = PH_REM_KLEN;
			end
			PH_REM_KLEN: begin
				if (v > KEY_LIMIT) begin
					sticky_status = ST_KEY;
				end else begin
					push_field(KIND_REM_KLEN, v, ST_OK);
					key_to_go = v[16:0];
					if (v != 0) cur_phase = PH_REM_KEY;
					else close_removal();
				end
			end
			default: begin
			end
		endcase
	endtask

	// Predict the results of one transferred payload byte.
	task automatic predict_byte(input logic [7:0] b, input logic last_flag);
		result_t tail;
		status_t end_status;
		value_t  v;
		pushed_now = 0;
		if (sticky_status == ST_OK) begin
			if (cur_phase == PH_DONE) begin
				sticky_status = ST_TRAILING;
			end else if (cur_phase == PH_ROW_KEY || cur_phase == PH_REM_KEY) begin
				if (cur_phase == PH_ROW_KEY) push_field(KIND_ROW_KEY, value_t'(b), ST_OK);
				else push_field(KIND_REM_KEY, value_t'(b), ST_OK);
				key_to_go--;
				if (key_to_go == 0) begin
					if (cur_phase == PH_ROW_KEY) cur_phase = PH_FILE_ID;
					else close_removal();
				end
			end else if (cur_phase == PH_TSTAMP) begin
				// The width is taken once, on the first timestamp byte.
				if (stamp_count == 0) stamp_wide = ts_wide_cfg;
				grp_acc |= value_t'(b) << {stamp_count[2:0], 3'b000};
				stamp_count++;
				if (stamp_count >= (stamp_wide ? 4'd8 : 4'd4)) begin
					push_field(KIND_TSTAMP, grp_acc, ST_OK);
					grp_acc     = '0;
					stamp_count = '0;
					cur_phase   = PH_DOCLEN;
				end
			end else if (grp_shift > 7'd63) begin
				sticky_status = ST_VARINT;
			end else begin
				grp_acc |= value_t'(b[6:0]) << grp_shift;
				if (!b[7]) begin
					grp_shift += 7'd7;
				end else begin
					v         = grp_acc;
					grp_acc   = '0;
					grp_shift = '0;
					finish_varint(v);
				end
			end
		end
		// The end flag always closes the section with its status.
		if (last_flag) begin
			end_status = sticky_status;
			if (end_status == ST_OK && cur_phase != PH_DONE) end_status = ST_TRUNCATED;
			push_field(KIND_SECTION_END, '0, end_status);
			clear_section();
		end
		if (pushed_now > 0) begin
			tail = pending_fields.pop_back();
			tail.run_last = 1'b1;
			pending_fields = {pending_fields, tail};
		end
	endtask

	// ------------------------------------------------------------------------
	// Section building
	// ------------------------------------------------------------------------

	// Append one byte to the section being built.
	task automatic add_byte(input logic [7:0] b);
		sec_q = {sec_q, b};
	endtask

	function automatic value_t rand_wide(input int maxw);
		value_t v;
		int     w;
		v = {$urandom, $urandom};
		w = $urandom_range(maxw, 0);
		return (w == 0) ? '0 : (v >> (64 - w));
	endfunction

	function automatic int varint_len(input value_t v);
		int n;
		n = 1;
		while (n < 10 && (v >> (7 * n)) != 0) n++;
		return n;
	endfunction

	// Append a varint of nb bytes, zero padded; nb of 0 gives the shortest form.
	task automatic put_varint(input value_t v, input int nb);
		if (nb == 0) nb = varint_len(v);
		for (int i = 0; i < nb; i++)
			add_byte({(i == nb - 1) ? 1'b1 : 1'b0, 7'(v >> (7 * i))});
	endtask

	task automatic put_int(input value_t v);
		int nb;
		nb = varint_len(v);
		if (fault_left == FAULT_LONG && $urandom_range(3) == 0) begin
			nb = 11;
			fault_left = FAULT_NONE;
		end else if ($urandom_range(7) == 0) begin
			nb = $urandom_range(10, nb);
		end
		put_varint(v, nb);
	endtask

	task automatic put_count(input int n);
		value_t v;
		v = value_t'(n);
		if (fault_left == FAULT_COUNT && $urandom_range(1) == 0) begin
			v = COUNT_LIMIT + 1 + rand_wide(20);
			fault_left = FAULT_NONE;
		end
		put_int(v);
	endtask

	task automatic put_u32();
		value_t v;
		v = rand_wide(32);
		if (fault_left == FAULT_WIDE && $urandom_range(2) == 0) begin
			v = rand_wide(64) | (value_t'(1) << 32);
			fault_left = FAULT_NONE;
		end
		put_int(v);
	endtask

	task automatic put_key();
		int klen;
		if (fault_left == FAULT_KEY && $urandom_range(1) == 0) begin
			put_int(KEY_LIMIT + 1 + rand_wide(16));
			fault_left = FAULT_NONE;
		end else begin
			klen = ($urandom_range(7) == 0) ? $urandom_range(20) : $urandom_range(3);
			put_int(value_t'(klen));
			repeat (klen) add_byte(8'($urandom));
		end
	endtask

	function automatic value_t rand_gap();
		return ($urandom_range(3) == 0) ? rand_wide(64) : rand_wide(14);
	endfunction

	// Build a complete section with random content and perhaps one planted fault.
	task automatic build_random_section(input fault_t fault);
		int nrows;
		int nrem;
		fault_left = fault;
		sec_q.delete();
		nrows = $urandom_range(2);
		nrem  = $urandom_range(2);
		put_count(nrows);
		for (int r = 0; r < nrows; r++) begin
			put_int(rand_gap());
			put_key();
			put_u32();
			put_int(rand_wide(64));
			put_u32();
			repeat (ts_wide_cfg ? 8 : 4) add_byte(8'($urandom));
			put_u32();
		end
		put_count(nrem);
		for (int r = 0; r < nrem; r++) begin
			put_int(rand_gap());
			put_key();
		end
	endtask

	// ------------------------------------------------------------------------
	// Channel drivers
	// ------------------------------------------------------------------------

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			IDLE_SENDER:   begin send_idle_pct = 65; recv_stall_pct = 0;  end
			IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 65; end
			default:       begin send_idle_pct = 23; recv_stall_pct = 23; end
		endcase
	endtask

	// Offer one payload byte, with random idle cycles ahead of it.
	task automatic send_byte(input logic [7:0] b, input logic last_flag);
		while ($urandom_range(99) < send_idle_pct) begin
			byte_ch.valid <= 1'b0;
			@(posedge clk);
		end
		byte_ch.valid        <= 1'b1;
		byte_ch.payload_byte <= b;
		byte_ch.payload_end  <= last_flag;
		do @(posedge clk); while (!byte_ch.ready);
		predict_byte(b, last_flag);
		bytes_sent++;
	endtask

	// Hold the sender off until every predicted result has been transferred.
	task automatic wait_drained();
		byte_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_fields.size() != 0);
	endtask

	task automatic send_section(input int pause_at);
		for (int i = 0; i < sec_q.size(); i++) begin
			if (i == pause_at) wait_drained();
			send_byte(sec_q[i], (i == sec_q.size() - 1) ? 1'b1 : 1'b0);
		end
	endtask

	// The width register is only written once the parser has gone quiet.
	task automatic write_timestamp_width(input logic wide);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_ch.valid          <= 1'b1;
		cfg_ch.timestamp_wide <= wide;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		ts_wide_cfg = wide;
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// One row and one removal with every field kind and extreme values.
	task automatic test_record_fields();
		sec_q.delete();
		put_varint(1, 0);
		// All 64 ordinal bits; the surplus group bits of the tenth byte are dropped.
		put_varint('1, 10);
		sec_q[sec_q.size() - 1] = 8'hFF;
		put_varint(1, 0);
		add_byte(8'hFF);
		put_varint(U32_MAX, 0);
		put_varint(0, 0);
		put_varint(0, 0);
		for (int i = 0; i < 8; i++) add_byte(8'h01 + 8'(i * 34));
		put_varint(1, 0);
		put_varint(1, 0);
		put_varint(5, 0);
		put_varint(1, 0);
		add_byte(8'h00);
		send_section(-1);
	endtask

	// A four byte timestamp is zero extended.
	task automatic test_narrow_timestamp();
		write_timestamp_width(1'b0);
		sec_q.delete();
		put_varint(1, 0);
		repeat (5) put_varint(0, 0);
		repeat (4) add_byte(8'hFF);
		put_varint(0, 0);
		put_varint(0, 0);
		send_section(-1);
	endtask

	// Empty lists, a byte past the end of the section and an early end.
	task automatic test_empty_and_trailing();
		sec_q.delete();
		put_varint(0, 0);
		put_varint(0, 0);
		send_section(-1);
		add_byte(8'h7E);
		send_section(-1);
		sec_q.delete();
		add_byte(8'h05);
		send_section(-1);
	endtask

	// Count and key limits just met and just exceeded, the 32-bit limit just exceeded, and a varint one byte too long.
	task automatic test_limits();
		sec_q.delete();
		put_varint(COUNT_LIMIT, 0);
		send_section(-1);
		sec_q.delete();
		put_varint(COUNT_LIMIT + 1, 0);
		send_section(-1);
		sec_q.delete();
		put_varint(1, 0);
		put_varint(0, 0);
		put_varint(KEY_LIMIT, 0);
		send_section(-1);
		sec_q.delete();
		put_varint(1, 0);
		put_varint(0, 0);
		put_varint(KEY_LIMIT + 1, 0);
		send_section(-1);
		sec_q.delete();
		put_varint(1, 0);
		put_varint(0, 0);
		put_varint(0, 0);
		put_varint(U32_MAX + 1, 0);
		send_section(-1);
		sec_q.delete();
		put_varint(0, 11);
		send_section(-1);
	endtask

	// Mostly well formed sections, some with a planted fault or damage.
	task automatic test_random_sections();
		int     sections;
		int     start;
		int     pick;
		int     cut;
		int     pause_at;
		fault_t fault;
		sections = 0;
		start    = bytes_sent;
		while (bytes_sent - start < RANDOM_BYTES) begin
			if (sections % 4 == 0) set_idling(idle_mode_t'($urandom_range(3)));
			if (sections % 7 == 6) write_timestamp_width(1'($urandom_range(1)));
			fault = ($urandom_range(99) < 20) ? fault_t'($urandom_range(4, 1)) : FAULT_NONE;
			build_random_section(fault);
			// Damage a share of the sections after they are built.
			pick = $urandom_range(99);
			if (pick < 10) begin
				if (sec_q.size() > 1) begin
					cut = $urandom_range(sec_q.size() - 1, 1);
					while (sec_q.size() > cut) void'(sec_q.pop_back());
				end
			end else if (pick < 18) begin
				repeat ($urandom_range(3, 1)) add_byte(8'($urandom));
			end else if (pick < 24) begin
				sec_q[$urandom_range(sec_q.size() - 1)] = 8'($urandom);
			end else if (pick < 30) begin
				sec_q.delete();
				repeat ($urandom_range(6, 1)) add_byte(8'($urandom));
			end
			pause_at = (sections == 2) ? sec_q.size() / 2 : -1;
			send_section(pause_at);
			sections++;
		end
	endtask

	// ------------------------------------------------------------------------
	// Result checking, receiver stalls and watchdog
	// ------------------------------------------------------------------------

	result_t got_rec;
	result_t want_rec;

	task automatic report_failure(input string what, input result_t want, input result_t got);
		failures++;
		if (failures <= MAX_REPORTS) begin
			$display("%0t %s: expected kind %0d value %h status %0d last %0b,",
				$time, what, want.kind, want.value, want.status, want.run_last);
			$display("    got kind %0d value %h status %0d last %0b",
				got.kind, got.value, got.status, got.run_last);
		end
	endtask

	// Compare every result transfer with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got_rec.kind     = res_ch.field_kind;
			got_rec.value    = res_ch.field_value;
			got_rec.status   = res_ch.section_status;
			got_rec.run_last = res_ch.run_last;
			if (pending_fields.size() == 0) begin
				report_failure("unexpected result", '0, got_rec);
			end else begin
				want_rec = pending_fields.pop_front();
				if (got_rec !== want_rec) report_failure("result mismatch", want_rec, got_rec);
			end
		end
	end

	// Receiver stalls at random.
	always @(posedge clk) res_ready <= ($urandom_range(99) >= recv_stall_pct);

	int idle_cycles = 0;

	// End the run if no transfer of any kind happens for too long.
	always @(posedge clk) begin
		if (!arst_n || (byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------

	initial begin
		arst_n                = 1'b0;
		byte_ch.valid         = 1'b0;
		byte_ch.payload_byte  = '0;
		byte_ch.payload_end   = 1'b0;
		cfg_ch.valid          = 1'b0;
		cfg_ch.timestamp_wide = 1'b0;
		ts_wide_cfg           = 1'b1;
		clear_section();
		set_idling(IDLE_NONE);
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		test_record_fields();
		test_empty_and_trailing();
		test_narrow_timestamp();
		test_limits();
		write_timestamp_width(1'b1);
		test_random_sections();

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/gvdr_pkg.sv
rtl/gvdr_byte_if.sv
rtl/gvdr_result_if.sv
rtl/gvdr_cfg_if.sv
rtl/gap_varint_delta_record_parser.sv
tb/tb_gap_varint_delta_record_parser.sv
